// ===== sv/rls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the regression leaf statistics block.
// Used by rls_ctrl, rls_datapath, regression_leaf_stats, leaf_checker and tb; depends on nothing.
package rls_pkg;

    // Command codes carried in the input tuser.
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_ADD_ROW = 3'd1;
    localparam logic [2:0] CMD_REM_ROW = 3'd2;
    localparam logic [2:0] CMD_MERGE   = 3'd3;
    localparam logic [2:0] CMD_UNMERGE = 3'd4;

    // Configuration register indexes.
    localparam logic REG_LOSS_FACTOR  = 1'b0;
    localparam logic REG_MISSING_LEAF = 1'b1;

    // Quotient bits produced by the restoring divider.
    localparam int DIV_STEPS = 17;

    localparam logic [15:0] LOSS_FACTOR_RST = 16'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROWSQ,
        ST_UPDATE,
        ST_DIVCHK,
        ST_DIV,
        ST_PRED,
        ST_MULA,
        ST_MULB,
        ST_MULC0,
        ST_MULC1,
        ST_SUM,
        ST_MULL0,
        ST_MULL1,
        ST_WSF,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROWSQ,
        OP_UPDATE,
        OP_DIVCHK,
        OP_DIVSTEP,
        OP_PRED,
        OP_MULA,
        OP_MULB,
        OP_MULC0,
        OP_MULC1,
        OP_SUM,
        OP_MULL0,
        OP_MULL1,
        OP_WSF,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/regression_leaf_stats.sv =====
`timescale 1ns / 1ps
// Top level of the regression leaf statistics block.
// Depends on rls_pkg, rls_ctrl and rls_datapath.
//
//  Channel   Direction  Carries
//  s_        in         one command item (cmd in tuser, operands in tdata)
//  m_        out        one result per item (flags in tuser, values in tdata)
//  cfg_      in         register writes: loss_factor, missing_leaf
//
// Each item steps through the sequencer; the restoring divider among its steps
// forms the prediction, one quotient bit a cycle.
// The next item is taken only once the result has been written to the output register.
// Reset is synchronous and active low; it clears the leaf and the configuration registers.
// A stalled result holds the sequencer in its last step until it is taken.
module regression_leaf_stats #(
    parameter int MAX_ROWS = 65536
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] target, [31:16] weight, [48:32] other_count, [80:49] other_weight_sum,
    // [128:81] other_weighted_target_sum, [190:129] other_weighted_sq_sum
    input  logic [191:0] s_tdata,
    // [2:0] cmd
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] prediction, [78:16] leaf_error, [110:79] missing_weight,
    // [173:111] capped_error, [190:174] row_count
    output logic [191:0] m_tdata,
    // [0] prediction_valid, [1] confidence
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    rls_pkg::dp_ctrl_t   ctrl;
    rls_pkg::dp_status_t status;

    rls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ctrl     (ctrl),
        .status   (status)
    );

    rls_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== sv/rls_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the leaf statistics block: walks each item through the datapath steps.
// Depends on rls_pkg.
module rls_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output rls_pkg::dp_ctrl_t   ctrl,
    input  rls_pkg::dp_status_t status
);

    rls_pkg::state_t state_reg, state_next;
    logic [4:0]      div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rls_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            rls_pkg::ST_IDLE:   if (s_tvalid) state_next = rls_pkg::ST_ROWSQ;
            rls_pkg::ST_ROWSQ:  state_next = rls_pkg::ST_UPDATE;
            rls_pkg::ST_UPDATE: state_next = rls_pkg::ST_DIVCHK;
            rls_pkg::ST_DIVCHK: begin
                state_next   = rls_pkg::ST_DIV;
                div_cnt_next = '0;
            end
            rls_pkg::ST_DIV: begin
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(rls_pkg::DIV_STEPS - 1)) state_next = rls_pkg::ST_PRED;
            end
            rls_pkg::ST_PRED:   state_next = rls_pkg::ST_MULA;
            rls_pkg::ST_MULA:   state_next = rls_pkg::ST_MULB;
            rls_pkg::ST_MULB:   state_next = rls_pkg::ST_MULC0;
            rls_pkg::ST_MULC0:  state_next = rls_pkg::ST_MULC1;
            rls_pkg::ST_MULC1:  state_next = rls_pkg::ST_SUM;
            rls_pkg::ST_SUM:    state_next = rls_pkg::ST_MULL0;
            rls_pkg::ST_MULL0:  state_next = rls_pkg::ST_MULL1;
            rls_pkg::ST_MULL1:  state_next = rls_pkg::ST_WSF;
            rls_pkg::ST_WSF:    state_next = rls_pkg::ST_OUT;
            rls_pkg::ST_OUT:    if (!status.out_busy) state_next = rls_pkg::ST_IDLE;
            default:            state_next = rls_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        ctrl.op  = rls_pkg::OP_NONE;
        unique case (state_reg)
            rls_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid) ctrl.op = rls_pkg::OP_LOAD;
            end
            rls_pkg::ST_ROWSQ:  ctrl.op = rls_pkg::OP_ROWSQ;
            rls_pkg::ST_UPDATE: ctrl.op = rls_pkg::OP_UPDATE;
            rls_pkg::ST_DIVCHK: ctrl.op = rls_pkg::OP_DIVCHK;
            rls_pkg::ST_DIV:    ctrl.op = rls_pkg::OP_DIVSTEP;
            rls_pkg::ST_PRED:   ctrl.op = rls_pkg::OP_PRED;
            rls_pkg::ST_MULA:   ctrl.op = rls_pkg::OP_MULA;
            rls_pkg::ST_MULB:   ctrl.op = rls_pkg::OP_MULB;
            rls_pkg::ST_MULC0:  ctrl.op = rls_pkg::OP_MULC0;
            rls_pkg::ST_MULC1:  ctrl.op = rls_pkg::OP_MULC1;
            rls_pkg::ST_SUM:    ctrl.op = rls_pkg::OP_SUM;
            rls_pkg::ST_MULL0:  ctrl.op = rls_pkg::OP_MULL0;
            rls_pkg::ST_MULL1:  ctrl.op = rls_pkg::OP_MULL1;
            rls_pkg::ST_WSF:    ctrl.op = rls_pkg::OP_WSF;
            rls_pkg::ST_OUT:    if (!status.out_busy) ctrl.op = rls_pkg::OP_OUT;
            default:            ctrl.op = rls_pkg::OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rls_pkg::ST_DIV |-> div_cnt_reg < 5'(rls_pkg::DIV_STEPS))
        else $error("divider step count ran past the quotient width");
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == rls_pkg::ST_ROWSQ)
        else $error("accepted item did not start the sequence");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == rls_pkg::OP_OUT |-> !status.out_busy)
        else $error("result written while the previous one is still waiting");
`endif

endmodule

// ===== sv/rls_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the leaf statistics block: leaf sums, divider, error products, result register.
// Depends on rls_pkg; driven step by step by rls_ctrl.
module rls_datapath #(
    parameter int MAX_ROWS = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rls_pkg::dp_ctrl_t   ctrl,
    output rls_pkg::dp_status_t status,
    input  logic [2:0]          s_tuser,
    input  logic [191:0]        s_tdata,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [15:0]         cfg_wdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [191:0]        m_tdata,
    output logic [1:0]          m_tuser
);

    localparam int          CNT_LIM_I = (MAX_ROWS < 131071) ? MAX_ROWS : 131071;
    localparam logic [16:0] CNT_LIM   = 17'(CNT_LIM_I);
    localparam logic [31:0] W_MAX     = 32'hFFFF_FFFF;
    localparam logic [61:0] S_MAX     = {62{1'b1}};
    localparam logic [62:0] ERR_MAX   = {63{1'b1}};

    // Configuration.
    logic [15:0] lf_reg;
    logic        miss_reg;

    // Captured item.
    logic [2:0]         cmd_reg;
    logic signed [15:0] tgt_reg;
    logic [15:0]        wgt_reg;
    logic [16:0]        oc_reg;
    logic [31:0]        ows_reg;
    logic [47:0]        owt_reg;
    logic [61:0]        osq_reg;
    logic [30:0]        tsq_reg;
    logic signed [32:0] wt_reg;
    logic [45:0]        sq_reg;

    // Leaf state.
    logic [16:0] cnt_reg;
    logic [31:0] w_reg;
    logic [47:0] t_reg;
    logic [61:0] s_reg;

    // Working registers.
    logic [47:0]        magt_reg;
    logic               tneg_reg;
    logic               ovf_reg;
    logic [31:0]        rem_reg;
    logic [16:0]        nsh_reg;
    logic [16:0]        q_reg;
    logic signed [15:0] pred_reg;
    logic [15:0]        pm_reg;
    logic               pneg_reg;
    logic [30:0]        pm2_reg;
    logic [54:0]        a_reg;
    logic [39:0]        pl_reg;
    logic [62:0]        bmag_reg;
    logic [63:0]        d_reg;
    logic [44:0]        el_reg;
    logic [62:0]        err_reg;
    logic [47:0]        wsf_reg;

    // Result register.
    logic               mv_reg;
    logic signed [15:0] o_pred_reg;
    logic               o_valid_reg;
    logic               o_conf_reg;
    logic [62:0]        o_err_reg;
    logic [31:0]        o_mw_reg;
    logic [62:0]        o_cap_reg;
    logic [16:0]        o_cnt_reg;

    // Update operands.
    logic [16:0]        dc;
    logic [31:0]        dw;
    logic [47:0]        dt;
    logic [61:0]        ds;
    logic [17:0]        cnt_sum;
    logic [32:0]        w_sum;
    logic signed [48:0] t_sum;
    logic signed [48:0] t_dif;
    logic [62:0]        s_sum;
    logic [16:0]        cnt_add, cnt_sub;
    logic [31:0]        w_add, w_sub;
    logic [47:0]        t_add, t_sub;
    logic [61:0]        s_add, s_sub;
    logic [16:0]        cnt_upd;
    logic [31:0]        w_upd;
    logic [47:0]        t_upd;
    logic [61:0]        s_upd;

    // Step logic.
    logic [47:0]  magt_c;
    logic [32:0]  r2;
    logic         ge;
    logic [32:0]  r2_sub;
    logic [62:0]  wpm2;
    logic [63:0]  bmag_c;
    logic [63:0]  b_c;
    logic [64:0]  pos_c;
    logic [64:0]  neg_c;
    logic [55:0]  hi_c;
    logic [23:0]  lo_c;
    logic [72:0]  e_full;
    logic         bneg_c;

    assign status.out_busy = m_tvalid && !m_tready;

    always_comb begin
        if (cmd_reg == rls_pkg::CMD_ADD_ROW || cmd_reg == rls_pkg::CMD_REM_ROW) begin
            dc = 17'd1;
            dw = {8'd0, wgt_reg, 8'd0};
            dt = 48'(wt_reg);
            ds = {16'd0, sq_reg};
        end else begin
            dc = oc_reg;
            dw = ows_reg;
            dt = owt_reg;
            ds = osq_reg;
        end

        cnt_sum = {1'b0, cnt_reg} + {1'b0, dc};
        cnt_add = (cnt_sum > {1'b0, CNT_LIM}) ? CNT_LIM : cnt_sum[16:0];
        cnt_sub = (dc >= cnt_reg) ? 17'd0 : cnt_reg - dc;

        w_sum = {1'b0, w_reg} + {1'b0, dw};
        w_add = w_sum[32] ? W_MAX : w_sum[31:0];
        w_sub = (dw >= w_reg) ? 32'd0 : w_reg - dw;

        // One guard bit catches overflow of the signed target sum.
        t_sum = signed'({t_reg[47], t_reg}) + signed'({dt[47], dt});
        t_dif = signed'({t_reg[47], t_reg}) - signed'({dt[47], dt});
        if (t_sum[48] != t_sum[47]) t_add = t_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else                        t_add = t_sum[47:0];
        if (t_dif[48] != t_dif[47]) t_sub = t_dif[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else                        t_sub = t_dif[47:0];

        s_sum = {1'b0, s_reg} + {1'b0, ds};
        s_add = s_sum[62] ? S_MAX : s_sum[61:0];
        s_sub = (ds >= s_reg) ? 62'd0 : s_reg - ds;

        cnt_upd = cnt_reg;
        w_upd   = w_reg;
        t_upd   = t_reg;
        s_upd   = s_reg;
        unique case (cmd_reg) inside
            rls_pkg::CMD_CLEAR: begin
                cnt_upd = '0;
                w_upd   = '0;
                t_upd   = '0;
                s_upd   = '0;
            end
            rls_pkg::CMD_ADD_ROW, rls_pkg::CMD_MERGE: begin
                cnt_upd = cnt_add;
                w_upd   = w_add;
                t_upd   = t_add;
                s_upd   = s_add;
            end
            rls_pkg::CMD_REM_ROW, rls_pkg::CMD_UNMERGE: begin
                cnt_upd = cnt_sub;
                w_upd   = w_sub;
                t_upd   = t_sub;
                s_upd   = s_sub;
            end
            default: begin
                cnt_upd = cnt_reg;
            end
        endcase
    end

    always_comb begin
        magt_c = t_reg[47] ? (48'd0 - t_reg) : t_reg;
        r2     = {rem_reg, nsh_reg[16]};
        ge     = r2 >= {1'b0, w_reg};
        r2_sub = r2 - {1'b0, w_reg};
        wpm2   = 63'(w_reg * pm2_reg);
        bmag_c = {24'd0, pl_reg} + ({16'd0, 48'(magt_reg[47:24] * pm_reg)} << 24);
        bneg_c = tneg_reg ^ pneg_reg;
        b_c    = {bmag_reg, 1'b0};
        pos_c  = {10'd0, a_reg} + {3'd0, s_reg} + (bneg_c ? {1'b0, b_c} : 65'd0);
        neg_c  = bneg_c ? 65'd0 : {1'b0, b_c};
        hi_c   = d_reg[63:8];
        lo_c   = 24'(d_reg[7:0] * lf_reg);
        e_full = {28'd0, el_reg} + ({29'd0, 44'(hi_c[55:28] * lf_reg)} << 28);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lf_reg   <= rls_pkg::LOSS_FACTOR_RST;
            miss_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rls_pkg::REG_LOSS_FACTOR:  lf_reg   <= cfg_wdata;
                rls_pkg::REG_MISSING_LEAF: miss_reg <= cfg_wdata[0];
                default:                   lf_reg   <= lf_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            w_reg   <= '0;
            t_reg   <= '0;
            s_reg   <= '0;
        end else if (ctrl.op == rls_pkg::OP_UPDATE) begin
            cnt_reg <= cnt_upd;
            w_reg   <= w_upd;
            t_reg   <= t_upd;
            s_reg   <= s_upd;
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            rls_pkg::OP_LOAD: begin
                cmd_reg <= s_tuser;
                tgt_reg <= signed'(s_tdata[15:0]);
                wgt_reg <= s_tdata[31:16];
                oc_reg  <= s_tdata[48:32];
                ows_reg <= s_tdata[80:49];
                owt_reg <= s_tdata[128:81];
                osq_reg <= s_tdata[190:129];
                tsq_reg <= 31'(signed'(s_tdata[15:0]) * signed'(s_tdata[15:0]));
                wt_reg  <= signed'({1'b0, s_tdata[31:16]}) * signed'(s_tdata[15:0]);
            end
            rls_pkg::OP_ROWSQ: sq_reg <= 46'(tsq_reg * wgt_reg);
            rls_pkg::OP_DIVCHK: begin
                magt_reg <= magt_c;
                tneg_reg <= t_reg[47];
                // Quotient of 2^17 or more saturates, so only 17 bits are divided out.
                ovf_reg  <= {9'd0, magt_c[47:9]} >= {16'd0, w_reg};
                rem_reg  <= magt_c[40:9];
                nsh_reg  <= {magt_c[8:0], 8'd0};
                q_reg    <= '0;
            end
            rls_pkg::OP_DIVSTEP: begin
                rem_reg <= ge ? r2_sub[31:0] : r2[31:0];
                q_reg   <= {q_reg[15:0], ge};
                nsh_reg <= {nsh_reg[15:0], 1'b0};
            end
            rls_pkg::OP_PRED: begin
                if (cnt_reg == 17'd0 || w_reg == 32'd0) begin
                    pred_reg <= '0;
                    pm_reg   <= '0;
                    pneg_reg <= 1'b0;
                end else if (tneg_reg) begin
                    pneg_reg <= ovf_reg || q_reg != 17'd0;
                    if (ovf_reg || q_reg > 17'd32768) begin
                        pred_reg <= signed'(16'h8000);
                        pm_reg   <= 16'h8000;
                    end else begin
                        pred_reg <= signed'(16'(17'd0 - q_reg));
                        pm_reg   <= q_reg[15:0];
                    end
                end else begin
                    pneg_reg <= 1'b0;
                    if (ovf_reg || q_reg > 17'd32767) begin
                        pred_reg <= 16'sd32767;
                        pm_reg   <= 16'd32767;
                    end else begin
                        pred_reg <= signed'(q_reg[15:0]);
                        pm_reg   <= q_reg[15:0];
                    end
                end
            end
            rls_pkg::OP_MULA:  pm2_reg  <= 31'(pm_reg * pm_reg);
            rls_pkg::OP_MULB:  a_reg    <= wpm2[62:8];
            rls_pkg::OP_MULC0: pl_reg   <= 40'(magt_reg[23:0] * pm_reg);
            rls_pkg::OP_MULC1: bmag_reg <= bmag_c[62:0];
            rls_pkg::OP_SUM:   d_reg    <= (pos_c > neg_c) ? 64'(pos_c - neg_c) : 64'd0;
            rls_pkg::OP_MULL0: el_reg   <= {1'b0, 44'(hi_c[27:0] * lf_reg)} + {29'd0, lo_c[23:8]};
            rls_pkg::OP_MULL1: err_reg  <= (e_full > {10'd0, ERR_MAX}) ? ERR_MAX : e_full[62:0];
            rls_pkg::OP_WSF:   wsf_reg  <= 48'(w_reg * lf_reg);
            rls_pkg::OP_OUT: begin
                o_valid_reg <= cnt_reg != 17'd0;
                o_pred_reg  <= pred_reg;
                o_conf_reg  <= (cnt_reg != 17'd0) && !miss_reg;
                o_cnt_reg   <= cnt_reg;
                o_mw_reg    <= (cnt_reg != 17'd0 && miss_reg) ? w_reg : 32'd0;
                if (cnt_reg != 17'd0 && !miss_reg) begin
                    o_err_reg <= err_reg;
                    o_cap_reg <= (err_reg > {15'd0, wsf_reg}) ? {15'd0, wsf_reg} : err_reg;
                end else begin
                    o_err_reg <= '0;
                    o_cap_reg <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (ctrl.op == rls_pkg::OP_OUT) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = {o_conf_reg, o_valid_reg};
    assign m_tdata  = {1'b0, o_cnt_reg, o_cap_reg, o_mw_reg, o_err_reg, o_pred_reg};

`ifndef SYNTHESIS
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LIM)
        else $error("row count above its limit");
    a_cap_below_err: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> o_cap_reg <= o_err_reg)
        else $error("capped error exceeds the error");
    a_empty_leaf: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !o_valid_reg |-> o_err_reg == 63'd0 && o_mw_reg == 32'd0 && !o_conf_reg)
        else $error("empty leaf reported nonzero statistics");
`endif

endmodule

// ===== sim/leaf_checker.sv =====
`timescale 1ns / 1ps
// Checker for regression_leaf_stats: watches the input, result and register ports,
// predicts each result from its own copy of the leaf sums and compares field by field.
// Depends on rls_pkg.
module leaf_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [191:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata,
    output int           errors,
    output int           pending
);

    localparam longint unsigned ROW_LIMIT  = 64'd65536;
    localparam longint unsigned WSUM_MAX   = 64'hFFFF_FFFF;
    localparam longint          WT_MAX     = 64'sh7FFF_FFFF_FFFF;
    localparam longint          WT_MIN     = -64'sh8000_0000_0000;
    localparam longint unsigned SQ_MAX     = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned ERROR_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] prediction;
        logic        pred_valid;
        logic        confidence;
        logic [62:0] leaf_error;
        logic [31:0] missing_weight;
        logic [62:0] capped_error;
        logic [16:0] row_count;
    } leaf_result_t;

    logic [15:0]    loss_factor;
    logic           missing_leaf;
    longint unsigned n_rows;
    longint unsigned w_sum;
    longint          wt_sum;
    longint unsigned sq_sum;

    leaf_result_t expected_q[$];

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                                longint unsigned hi);
        if (a > hi) a = hi;
        if (b > hi - a) return hi;
        return a + b;
    endfunction

    function automatic longint unsigned sub_sat(longint unsigned a, longint unsigned b);
        return (b >= a) ? 64'd0 : a - b;
    endfunction

    function automatic longint clamp_wt(longint v);
        if (v > WT_MAX) return WT_MAX;
        if (v < WT_MIN) return WT_MIN;
        return v;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // Updates the leaf sums for one command and works out the result it reports.
    task automatic update_leaf(input logic [2:0] cmd, input logic [191:0] d,
                               output leaf_result_t r);
        longint          tgt, owt, wt, pred, bp;
        longint unsigned wgt, oc, ows, osq, sq, q, pm, a, b, pos, neg, diff, hi, lo;
        longint unsigned err, cap, wsf, lf;
        tgt = longint'($signed(d[15:0]));
        wgt = d[31:16];
        oc  = d[48:32];
        ows = d[80:49];
        owt = longint'($signed(d[128:81]));
        osq = d[190:129];
        lf  = loss_factor;
        pred = 0; err = 0; cap = 0;
        r = '0;
        case (cmd) inside
            rls_pkg::CMD_CLEAR: begin
                n_rows = 0; w_sum = 0; wt_sum = 0; sq_sum = 0;
            end
            rls_pkg::CMD_ADD_ROW, rls_pkg::CMD_REM_ROW: begin
                wt = longint'(wgt) * tgt;
                sq = longint'(tgt * tgt) * wgt;
                if (cmd == rls_pkg::CMD_ADD_ROW) begin
                    n_rows = add_sat(n_rows, 1, ROW_LIMIT);
                    w_sum  = add_sat(w_sum, wgt << 8, WSUM_MAX);
                    wt_sum = clamp_wt(wt_sum + wt);
                    sq_sum = add_sat(sq_sum, sq, SQ_MAX);
                end else begin
                    n_rows = sub_sat(n_rows, 1);
                    w_sum  = sub_sat(w_sum, wgt << 8);
                    wt_sum = clamp_wt(wt_sum - wt);
                    sq_sum = sub_sat(sq_sum, sq);
                end
            end
            rls_pkg::CMD_MERGE: begin
                n_rows = add_sat(n_rows, oc, ROW_LIMIT);
                w_sum  = add_sat(w_sum, ows, WSUM_MAX);
                wt_sum = clamp_wt(wt_sum + owt);
                sq_sum = add_sat(sq_sum, osq, SQ_MAX);
            end
            rls_pkg::CMD_UNMERGE: begin
                n_rows = sub_sat(n_rows, oc);
                w_sum  = sub_sat(w_sum, ows);
                wt_sum = clamp_wt(wt_sum - owt);
                sq_sum = sub_sat(sq_sum, osq);
            end
            default: ;
        endcase

        if (n_rows > 0) begin
            r.pred_valid = 1'b1;
            if (w_sum != 0) begin
                q = (magnitude(wt_sum) << 8) / w_sum;
                if (wt_sum < 0) pred = (q > 32768) ? -32768 : -longint'(q);
                else            pred = (q > 32767) ? 32767 : longint'(q);
            end
            if (missing_leaf) begin
                r.missing_weight = w_sum[31:0];
            end else begin
                r.confidence = 1'b1;
                pm  = magnitude(pred);
                a   = (w_sum * (pm * pm)) >> 8;
                bp  = wt_sum * pred;
                b   = magnitude(bp) << 1;
                pos = a + sq_sum;
                neg = 0;
                // The cross term adds to the error when it is negative.
                if (bp < 0) pos = pos + b;
                else        neg = b;
                if (pos > neg) begin
                    diff = pos - neg;
                    hi   = diff >> 8;
                    lo   = ((diff & 64'hFF) * lf) >> 8;
                    if (lf != 0 && hi > ERROR_MAX / lf) begin
                        err = ERROR_MAX;
                    end else begin
                        err = hi * lf + lo;
                        if (err > ERROR_MAX) err = ERROR_MAX;
                    end
                end
                wsf = w_sum * lf;
                cap = (err > wsf) ? wsf : err;
            end
        end
        r.prediction   = pred[15:0];
        r.leaf_error   = err[62:0];
        r.capped_error = cap[62:0];
        r.row_count    = n_rows[16:0];
    endtask

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] exp);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, exp);
        errors++;
    endtask

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        leaf_result_t exp_r, got_r;
        if (!aresetn) begin
            loss_factor  <= rls_pkg::LOSS_FACTOR_RST;
            missing_leaf <= 1'b0;
            n_rows = 0; w_sum = 0; wt_sum = 0; sq_sum = 0;
            expected_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == rls_pkg::REG_LOSS_FACTOR) loss_factor <= cfg_wdata;
                else                                      missing_leaf <= cfg_wdata[0];
            end
            if (s_tvalid && s_tready) begin
                update_leaf(s_tuser, s_tdata, exp_r);
                expected_q.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                got_r.prediction     = m_tdata[15:0];
                got_r.leaf_error     = m_tdata[78:16];
                got_r.missing_weight = m_tdata[110:79];
                got_r.capped_error   = m_tdata[173:111];
                got_r.row_count      = m_tdata[190:174];
                got_r.pred_valid     = m_tuser[0];
                got_r.confidence     = m_tuser[1];
                if (expected_q.size() == 0) begin
                    report("unexpected transfer", 64'd1, 64'd0);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r.prediction != exp_r.prediction)
                        report("prediction", got_r.prediction, exp_r.prediction);
                    if (got_r.pred_valid != exp_r.pred_valid)
                        report("prediction_valid", got_r.pred_valid, exp_r.pred_valid);
                    if (got_r.confidence != exp_r.confidence)
                        report("confidence", got_r.confidence, exp_r.confidence);
                    if (got_r.leaf_error != exp_r.leaf_error)
                        report("leaf_error", got_r.leaf_error, exp_r.leaf_error);
                    if (got_r.missing_weight != exp_r.missing_weight)
                        report("missing_weight", got_r.missing_weight, exp_r.missing_weight);
                    if (got_r.capped_error != exp_r.capped_error)
                        report("capped_error", got_r.capped_error, exp_r.capped_error);
                    if (got_r.row_count != exp_r.row_count)
                        report("row_count", got_r.row_count, exp_r.row_count);
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the regression_leaf_stats testbench: clock, reset, stimulus, receiver stalls
// and the verdict. Depends on rls_pkg, regression_leaf_stats and leaf_checker.
module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1100;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wr_en;
    logic         cfg_addr;
    logic [15:0]  cfg_wdata;
    int           errors;
    int           pending;
    int           cycles;
    int           hold_left;
    logic         hold_go;
    int           burst_left;

    regression_leaf_stats i_dut (.*);

    leaf_checker i_checker (.*);

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: its stall pattern steps through four modes in turn; a requested hold-off
    // keeps tready low for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_go) begin
            m_tready  <= 1'b0;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            case ((cycles / 64) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic logic [191:0] pack_item(logic [15:0] tgt, logic [15:0] wgt,
                                              logic [16:0] oc, logic [31:0] ows,
                                              logic [47:0] owt, logic [61:0] osq);
        return {1'b0, osq, owt, ows, oc, wgt, tgt};
    endfunction

    // Offers one item and returns once it has been transferred. Bursts of random
    // length are separated by random gaps.
    task automatic send_item(input logic [2:0] cmd, input logic [191:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_random();
        int          pick;
        logic [2:0]  cmd;
        logic [63:0] r1, r2;
        pick = $urandom_range(0, 99);
        r1 = rand64();
        r2 = rand64();
        if (pick < 55)      cmd = rls_pkg::CMD_ADD_ROW;
        else if (pick < 78) cmd = rls_pkg::CMD_REM_ROW;
        else if (pick < 86) cmd = rls_pkg::CMD_MERGE;
        else if (pick < 92) cmd = rls_pkg::CMD_UNMERGE;
        else if (pick < 96) cmd = rls_pkg::CMD_CLEAR;
        else                cmd = 3'($urandom_range(5, 7));
        // Merge operands are shifted down at random so most stay in a useful range.
        send_item(cmd, pack_item(16'($urandom()), 16'($urandom()),
                                 17'($urandom_range(0, 65536)),
                                 32'($urandom() >> $urandom_range(0, 31)),
                                 48'($signed(r1) >>> $urandom_range(16, 63)),
                                 62'(r2 >> $urandom_range(2, 63))));
    endtask

    task automatic directed_set();
        send_item(rls_pkg::CMD_CLEAR, '0);
        send_item(rls_pkg::CMD_REM_ROW, pack_item(16'h0100, 16'h0100, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_ADD_ROW, pack_item(16'h7FFF, 16'hFFFF, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_ADD_ROW, pack_item(16'h8000, 16'hFFFF, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_ADD_ROW, pack_item(16'h8000, 16'h0100, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_REM_ROW, pack_item(16'h7FFF, 16'hFFFF, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_MERGE, pack_item('0, '0, 17'd65536, 32'hFFFF_FFFF,
                                       48'h7FFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFF));
        send_item(rls_pkg::CMD_MERGE, pack_item('0, '0, 17'd65536, 32'hFFFF_FFFF,
                                       48'h7FFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFF));
        send_item(rls_pkg::CMD_UNMERGE, pack_item('0, '0, 17'd1, 32'h0000_0100,
                                         48'h8000_0000_0000, 62'd0));
        send_item(rls_pkg::CMD_UNMERGE, pack_item('1, '1, 17'h1FFFF, 32'hFFFF_FFFF,
                                         48'h7FFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFFF));
        // Rows with zero weight leave the weight sum at zero.
        send_item(rls_pkg::CMD_ADD_ROW, pack_item(16'h1234, 16'h0000, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_ADD_ROW, pack_item(16'hFF00, 16'h0000, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_MERGE, pack_item('0, '0, '0, '0, 48'hFFFF_FFFF_0000, '0));
        send_item(rls_pkg::CMD_ADD_ROW, pack_item(16'h0300, 16'h0080, '0, '0, '0, '0));
        send_item(rls_pkg::CMD_ADD_ROW, pack_item(16'hFD00, 16'h0200, '0, '0, '0, '0));
        send_item(3'd5, pack_item('1, '1, '1, '1, '1, '1));
        send_item(3'd6, '0);
        send_item(3'd7, '0);
        send_item(rls_pkg::CMD_MERGE, pack_item('0, '0, 17'd3, 32'h0003_0000,
                                       48'h8000_0000_0000, 62'h0000_0100_0000_0000));
        send_item(rls_pkg::CMD_CLEAR, '1);
    endtask

    initial begin
        logic [15:0] factor_set [5];
        factor_set = '{16'd256, 16'd0, 16'hFFFF, 16'd1, 16'd1000};
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = rls_pkg::REG_LOSS_FACTOR;
        cfg_wdata  = '0;
        hold_go    = 1'b0;
        burst_left = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_set();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 5) write_reg(rls_pkg::REG_LOSS_FACTOR, factor_set[ph]);
            write_reg(rls_pkg::REG_MISSING_LEAF, {15'd0, ph == 3 || ph == 5});
            if (ph == 3) directed_set();
            for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
                if (ph == 1 && k == 20) begin
                    hold_go <= 1'b1;
                    @(posedge aclk);
                    hold_go <= 1'b0;
                end
                send_random();
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rls_pkg.sv
sv/rls_ctrl.sv
sv/rls_datapath.sv
sv/regression_leaf_stats.sv
sim/leaf_checker.sv
sim/tb.sv
